// ===== design/par_pkg.sv =====
`default_nettype none

package par_pkg;

   // Field and register widths
   localparam int unsigned LEN_W     = 11;
   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned SUM_W     = 27;
   // Holds position times length products, up to 2047 * 2047 plus one length
   localparam int unsigned PROD_W    = 23;
   localparam int unsigned CSR_IDX_W = 2;

   // Default upper bound on a series length
   localparam int unsigned MAX_LENGTH = 1024;

   // Output length is limited to this power of two times the input length
   localparam int unsigned UPSAMPLE_SHIFT = 6;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LENGTH = 2'd1;

   // Register reset values
   localparam logic [LEN_W-1:0] INPUT_LENGTH_RST  = 11'd1024;
   localparam logic [LEN_W-1:0] OUTPUT_LENGTH_RST = 11'd64;

   // Divider launch request: magnitude of the segment sum over the segment length
   typedef struct packed {
      logic             start;
      logic             negate;
      logic [SUM_W-1:0] magnitude;
      logic [LEN_W-1:0] divisor;
   } div_req_type;

endpackage

`default_nettype wire

// ===== design/piecewise_aggregate_resampler_top.sv =====
// Downsampling: a sample that closes no segment leaves the block idle for the
// next sample; one that closes a segment stalls input until the 27-step
// bit-serial mean divider is done and the mean is loaded. Upsampling: a sample
// is repeated (1..64 outputs), paced by the single output register, input stalled.
// Synchronous active-high reset: lengths return to 1024 and 64, series restarts.
`default_nettype none

module piecewise_aggregate_resampler_top #(
   parameter int unsigned MAX_LENGTH = par_pkg::MAX_LENGTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Sample input
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [par_pkg::SAMPLE_W-1:0] req_sample,
   // Resampled output
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [par_pkg::SAMPLE_W-1:0]     rsp_value,
   output logic                                    rsp_last,
   // Register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [par_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [par_pkg::LEN_W-1:0]          csr_wdata
);

   localparam int unsigned LEN_W    = par_pkg::LEN_W;
   localparam int unsigned SAMPLE_W = par_pkg::SAMPLE_W;
   localparam int unsigned SUM_W    = par_pkg::SUM_W;
   localparam int unsigned PROD_W   = par_pkg::PROD_W;
   localparam int unsigned UP_W     = LEN_W + par_pkg::UPSAMPLE_SHIFT;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_REPEAT
   } state_type;

   state_type                state_ff, state_in;
   logic [LEN_W-1:0]         in_len_ff, in_len_in;
   logic [LEN_W-1:0]         out_len_ff, out_len_in;
   logic [LEN_W-1:0]         ip_ff, ip_in;
   logic [LEN_W-1:0]         op_ff, op_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [LEN_W-1:0]         seg_start_ff, seg_start_in;
   logic [PROD_W-1:0]        prod_out_ff, prod_out_in;  // op * n_in
   logic [PROD_W-1:0]        prod_in_ff, prod_in_in;    // ip * n_out
   logic [SAMPLE_W-1:0]      samp_ff, samp_in;
   logic                     restart_pend_ff, restart_pend_in;
   logic                     div_last_ff, div_last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0]         n_in;
   logic [LEN_W-1:0]         n_out_sat;
   logic [LEN_W-1:0]         n_out;
   logic [UP_W-1:0]          up_limit;
   logic                     down_mode;
   logic [LEN_W-1:0]         next_pos;
   logic [PROD_W-1:0]        prod_in_step;
   logic [PROD_W-1:0]        prod_out_step;
   logic signed [SUM_W-1:0]  sum_new;
   logic                     slot_free;
   logic                     restart_now;
   logic                     at_last_out;

   par_pkg::div_req_type     div_req;
   logic                     div_busy;
   logic [SAMPLE_W-1:0]      div_quotient;

   par_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // Effective lengths: zero reads as one, saturate at MAX_LENGTH
   always_comb begin
      if (in_len_ff == '0) begin
         n_in = LEN_W'(1);
      end else if (32'(in_len_ff) > MAX_LENGTH) begin
         n_in = LEN_W'(MAX_LENGTH);
      end else begin
         n_in = in_len_ff;
      end
      if (out_len_ff == '0) begin
         n_out_sat = LEN_W'(1);
      end else if (32'(out_len_ff) > MAX_LENGTH) begin
         n_out_sat = LEN_W'(MAX_LENGTH);
      end else begin
         n_out_sat = out_len_ff;
      end
   end

   // Upsampling ratio limit
   assign up_limit  = {n_in, {par_pkg::UPSAMPLE_SHIFT{1'b0}}};
   assign n_out     = (UP_W'(n_out_sat) > up_limit) ? up_limit[LEN_W-1:0] : n_out_sat;
   assign down_mode = (n_out <= n_in);

   assign next_pos      = ip_ff + 1'b1;
   assign prod_in_step  = prod_in_ff + PROD_W'(n_out);
   assign prod_out_step = prod_out_ff + PROD_W'(n_in);
   assign sum_new       = sum_ff + SUM_W'(req_sample);
   assign slot_free     = ~rsp_valid_ff | ~rsp_stall;
   assign at_last_out   = (op_ff == (n_out - 1'b1));

   // Next-state logic
   always_comb begin
      state_in        = state_ff;
      in_len_in       = in_len_ff;
      out_len_in      = out_len_ff;
      ip_in           = ip_ff;
      op_in           = op_ff;
      sum_in          = sum_ff;
      seg_start_in    = seg_start_ff;
      prod_out_in     = prod_out_ff;
      prod_in_in      = prod_in_ff;
      samp_in         = samp_ff;
      restart_pend_in = restart_pend_ff;
      div_last_in     = div_last_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_value_in    = rsp_value_ff;
      rsp_last_in     = rsp_last_ff;
      restart_now     = 1'b0;
      div_req         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               // Register write; a valid index restarts the series
               case (csr_index)
                  par_pkg::CSR_INPUT_LENGTH: begin
                     in_len_in   = csr_wdata;
                     restart_now = 1'b1;
                  end
                  par_pkg::CSR_OUTPUT_LENGTH: begin
                     out_len_in  = csr_wdata;
                     restart_now = 1'b1;
                  end
                  default: ;
               endcase
            end else if (req_valid) begin
               ip_in      = next_pos;
               prod_in_in = prod_in_step;
               if (down_mode) begin
                  // Segment closes when (op+1)*n_in < (next+1)*n_out
                  if ((op_ff < n_out) &&
                      ((prod_out_step) < (prod_in_step + PROD_W'(n_out)))) begin
                     div_req.start     = 1'b1;
                     div_req.negate    = sum_new[SUM_W-1];
                     div_req.magnitude = sum_new[SUM_W-1] ? SUM_W'(-sum_new)
                                                          : SUM_W'(sum_new);
                     div_req.divisor   = next_pos - seg_start_ff;
                     div_last_in       = at_last_out;
                     op_in             = op_ff + 1'b1;
                     prod_out_in       = prod_out_step;
                     sum_in            = '0;
                     seg_start_in      = next_pos;
                     state_in          = ST_DIV;
                  end else begin
                     sum_in = sum_new;
                  end
                  restart_now = (next_pos >= n_in);
               end else begin
                  samp_in         = req_sample;
                  restart_pend_in = (next_pos >= n_in);
                  state_in        = ST_REPEAT;
               end
            end
         end

         ST_DIV: begin
            // Hand the mean to the output register once the divider is done and the slot is free
            if (!div_busy && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = div_quotient;
               rsp_last_in  = div_last_ff;
               state_in     = ST_IDLE;
            end
         end

         ST_REPEAT: begin
            // Repeat the sample while op*n_in < next*n_out
            if ((op_ff < n_out) && (prod_out_ff < prod_in_ff)) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = samp_ff;
                  rsp_last_in  = at_last_out;
                  op_in        = op_ff + 1'b1;
                  prod_out_in  = prod_out_step;
               end
            end else begin
               restart_now = restart_pend_ff;
               state_in    = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // Series restart clears all position state
      if (restart_now) begin
         ip_in        = '0;
         op_in        = '0;
         sum_in       = '0;
         seg_start_in = '0;
         prod_out_in  = '0;
         prod_in_in   = '0;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         in_len_ff       <= par_pkg::INPUT_LENGTH_RST;
         out_len_ff      <= par_pkg::OUTPUT_LENGTH_RST;
         ip_ff           <= '0;
         op_ff           <= '0;
         sum_ff          <= '0;
         seg_start_ff    <= '0;
         prod_out_ff     <= '0;
         prod_in_ff      <= '0;
         restart_pend_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         in_len_ff       <= in_len_in;
         out_len_ff      <= out_len_in;
         ip_ff           <= ip_in;
         op_ff           <= op_in;
         sum_ff          <= sum_in;
         seg_start_ff    <= seg_start_in;
         prod_out_ff     <= prod_out_in;
         prod_in_ff      <= prod_in_in;
         restart_pend_ff <= restart_pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      samp_ff      <= samp_in;
      div_last_ff  <= div_last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // A register write takes the idle cycle, so samples wait behind it
   assign req_stall = (state_ff != ST_IDLE) | csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

`ifndef ASSERT_OFF
   // The divider only runs while the control waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == ST_DIV))
      else $error("divider busy outside mean state");

   // Segment start never passes the input position
   a_seg_order: assert property (@(posedge clock) disable iff (reset)
      seg_start_ff <= ip_ff)
      else $error("segment start beyond input position");

   // Output position never runs past the output length
   a_op_bound: assert property (@(posedge clock) disable iff (reset)
      op_ff <= n_out)
      else $error("output position beyond output length");

   // A finished mean is loaded into the output register when the slot is free
   a_mean_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && !div_busy && slot_free |=> rsp_valid_ff)
      else $error("finished mean not loaded");
`endif

endmodule

`default_nettype wire

// ===== design/par_div.sv =====
`default_nettype none

// Bit-serial restoring divider: one quotient bit per cycle shifted in at the
// bottom of the dividend register, sign applied at the output.
module par_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire par_pkg::div_req_type        req,
   output logic                             busy,
   output logic [par_pkg::SAMPLE_W-1:0]     quotient
);

   localparam int unsigned DVD_W = par_pkg::SUM_W;
   localparam int unsigned DVS_W = par_pkg::LEN_W;
   localparam int unsigned CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] den_ff;
   logic             neg_ff;

   logic [DVS_W:0]   shifted;
   logic [DVS_W+1:0] trial;
   logic             qbit;

   // Trial subtract of the divisor from the partial remainder
   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign qbit    = ~trial[DVS_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= LAST_STEP;
         rem_ff  <= '0;
         quo_ff  <= req.magnitude;
         den_ff  <= req.divisor;
         neg_ff  <= req.negate;
      end else if (busy_ff) begin
         rem_ff <= qbit ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_ff <= {quo_ff[DVD_W-2:0], qbit};
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign busy     = busy_ff;
   // Truncation toward zero: divide magnitudes, then restore the sign
   assign quotient = neg_ff ? (~quo_ff[par_pkg::SAMPLE_W-1:0] + 1'b1)
                            : quo_ff[par_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ===== dv/tb_piecewise_aggregate_resampler_top.sv =====
`timescale 1ns / 100ps

module tb_piecewise_aggregate_resampler_top;

   localparam int unsigned LEN_W     = par_pkg::LEN_W;
   localparam int unsigned SAMPLE_W  = par_pkg::SAMPLE_W;
   localparam int unsigned CSR_IDX_W = par_pkg::CSR_IDX_W;

   // Register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_3 = 2'd3;

   // Random part of the run; the directed tests add 33 samples
   localparam int RANDOM_SAMPLES = 245;
   // Idle cycles before a register write, covers a mean division in flight
   localparam int SETTLE_CYCLES  = 40;
   localparam int DRAIN_CYCLES   = 80;
   localparam int REPEAT_LIMIT   = 1 << par_pkg::UPSAMPLE_SHIFT;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic                       last;
   } resampled_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_value;
   logic                       rsp_last;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [LEN_W-1:0]           csr_wdata;

   piecewise_aggregate_resampler_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_last),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predicted resampler state and register copies
   logic [LEN_W-1:0] input_length_reg;
   logic [LEN_W-1:0] output_length_reg;
   longint           next_input_index;
   longint           next_output_index;
   longint           running_sum;
   longint           segment_first;

   resampled_type pending_outputs[$];

   int  error_count;
   int  samples_sent;
   int  random_sent;
   int  outputs_checked;
   int  register_writes;
   bit  gaps_enabled;
   bit  stalls_enabled;
   int  stall_hold;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Length actually used for a register value: zero acts as one, large values saturate
   function automatic longint clamp_length(input logic [LEN_W-1:0] reg_value);
      if (reg_value == '0) return 1;
      if (reg_value > par_pkg::MAX_LENGTH) return par_pkg::MAX_LENGTH;
      return reg_value;
   endfunction

   function automatic void clear_series_state();
      next_input_index  = 0;
      next_output_index = 0;
      running_sum       = 0;
      segment_first     = 0;
   endfunction

   function automatic void queue_output(input logic signed [SAMPLE_W-1:0] value,
                                        input logic last);
      resampled_type item;
      item.value = value;
      item.last  = last;
      pending_outputs.push_back(item);
   endfunction

   // Advance the series by one sample and queue the outputs it produces
   function automatic void predict_resampled(input logic signed [SAMPLE_W-1:0] sample);
      longint n_in;
      longint n_out;
      longint nxt;
      longint boundary;
      longint seg_len;
      longint mean;
      int     emitted;
      n_in  = clamp_length(input_length_reg);
      n_out = clamp_length(output_length_reg);
      nxt   = next_input_index + 1;
      emitted = 0;
      if (n_out > n_in * REPEAT_LIMIT) n_out = n_in * REPEAT_LIMIT;
      if (n_out <= n_in) begin
         // Downsampling: segment mean, truncated toward zero
         boundary = ((next_output_index + 1) * n_in) / n_out;
         running_sum += sample;
         if (nxt >= boundary && next_output_index < n_out) begin
            seg_len = nxt - segment_first;
            if (seg_len == 0) seg_len = 1;
            mean = running_sum / seg_len;
            queue_output(mean[SAMPLE_W-1:0], next_output_index == n_out - 1);
            next_output_index++;
            running_sum   = 0;
            segment_first = nxt;
         end
      end else begin
         // Upsampling: repeat the sample for every output that maps onto it
         while (emitted < REPEAT_LIMIT && next_output_index < n_out &&
                next_output_index * n_in < nxt * n_out) begin
            queue_output(sample, next_output_index == n_out - 1);
            emitted++;
            next_output_index++;
         end
      end
      if (nxt >= n_in) clear_series_state();
      else next_input_index = nxt;
   endfunction

   // Sender idle length: mostly none or short, now and then long
   function automatic int sender_gap();
      int pick;
      if (!gaps_enabled) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // One sample transfer; valid stays high on return
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (req_stall);
      predict_resampled(sample);
      samples_sent++;
   endtask

   // Register write, only once the block has gone idle
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [LEN_W-1:0] data);
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      register_writes++;
      if (index == par_pkg::CSR_INPUT_LENGTH) begin
         input_length_reg = data;
         clear_series_state();
      end else if (index == par_pkg::CSR_OUTPUT_LENGTH) begin
         output_length_reg = data;
         clear_series_state();
      end
   endtask

   // Reset lengths 1024 and 64: sixteen samples close the first segment
   task automatic test_reset_lengths();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      repeat (14) send_sample(random_sample());
   endtask

   // Uneven segments of 2 and 3 samples, negative sum truncates toward zero
   task automatic test_segment_means();
      write_register(par_pkg::CSR_INPUT_LENGTH, 11'd5);
      write_register(par_pkg::CSR_OUTPUT_LENGTH, 11'd2);
      send_sample(-16'sd3);
      send_sample(-16'sd4);
      send_sample(16'sd100);
      send_sample(-16'sd1);
      send_sample(16'sd0);
   endtask

   // Unmapped indexes leave the series running
   task automatic test_unmapped_index();
      send_sample(16'sd7);
      write_register(CSR_UNMAPPED_2, 11'd3);
      write_register(CSR_UNMAPPED_3, 11'h7FF);
      send_sample(-16'sd8);
      send_sample(16'sd9);
   endtask

   // Plain upsampling, several repeats per sample
   task automatic test_upsample_repeat();
      write_register(par_pkg::CSR_INPUT_LENGTH, 11'd3);
      write_register(par_pkg::CSR_OUTPUT_LENGTH, 11'd8);
      send_sample(16'sh0100);
      send_sample(-16'sh0100);
      send_sample(16'sh7FFF);
   endtask

   // Output length saturates, then is capped at 64 repeats of a one-sample series
   task automatic test_upsample_cap();
      write_register(par_pkg::CSR_INPUT_LENGTH, 11'd1);
      write_register(par_pkg::CSR_OUTPUT_LENGTH, 11'h7FF);
      send_sample(16'sh8000);
      send_sample(16'sh1234);
   endtask

   // Zero lengths act as one: every sample is a whole series
   task automatic test_zero_lengths();
      write_register(par_pkg::CSR_INPUT_LENGTH, 11'd0);
      write_register(par_pkg::CSR_OUTPUT_LENGTH, 11'd0);
      send_sample(-16'sd1);
      send_sample(16'sh7FFF);
   endtask

   // Saturated input length with equal output length: every sample closes a segment
   task automatic test_saturated_lengths();
      write_register(par_pkg::CSR_INPUT_LENGTH, 11'h7FF);
      write_register(par_pkg::CSR_OUTPUT_LENGTH, 11'd1024);
      send_sample(16'sh8000);
      send_sample(16'sh5A5A);
   endtask

   // Random length settings, mostly whole series, with random idling
   task automatic test_random_series();
      logic [LEN_W-1:0]           in_reg;
      logic [LEN_W-1:0]           out_reg;
      logic signed [SAMPLE_W-1:0] extreme_value;
      bit                         hold_extreme;
      longint                     n_in;
      int                         up_max;
      int                         count;
      while (random_sent < RANDOM_SAMPLES) begin
         case ($urandom_range(0, 9))
            0:       in_reg = '0;
            1:       in_reg = LEN_W'($urandom_range(1025, 2047));
            2:       in_reg = LEN_W'($urandom_range(41, 1024));
            default: in_reg = LEN_W'($urandom_range(1, 40));
         endcase
         n_in   = clamp_length(in_reg);
         up_max = (n_in * 70 > 2047) ? 2047 : int'(n_in * 70);
         case ($urandom_range(0, 9))
            0:             out_reg = '0;
            1:             out_reg = LEN_W'($urandom_range(1025, 2047));
            2, 3, 4, 5:    out_reg = LEN_W'($urandom_range(1, int'(n_in)));
            default:       out_reg = LEN_W'($urandom_range(int'(n_in), up_max));
         endcase
         if ($urandom_range(0, 1)) begin
            write_register(par_pkg::CSR_INPUT_LENGTH, in_reg);
            write_register(par_pkg::CSR_OUTPUT_LENGTH, out_reg);
         end else begin
            write_register(par_pkg::CSR_OUTPUT_LENGTH, out_reg);
            write_register(par_pkg::CSR_INPUT_LENGTH, in_reg);
         end
         gaps_enabled   = ($urandom_range(0, 3) != 0);
         stalls_enabled = ($urandom_range(0, 3) != 0);
         // Some series hold one extreme value to push the sum to its range
         hold_extreme  = ($urandom_range(0, 5) == 0);
         extreme_value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         count = (n_in <= 40) ? int'(n_in) * $urandom_range(1, 3) : $urandom_range(1, 30);
         if ($urandom_range(0, 3) == 0)
            count += $urandom_range(1, (n_in <= 40) ? int'(n_in) : 10);
         if (count > RANDOM_SAMPLES - random_sent) count = RANDOM_SAMPLES - random_sent;
         repeat (count) begin
            send_sample(hold_extreme ? extreme_value : random_sample());
            random_sent++;
         end
      end
   endtask

   // Result receiver stall bursts
   always @(posedge clock) begin : stall_driver
      int pick;
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if (!stalls_enabled) begin
         rsp_stall <= 1'b0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 6);
         end else if (pick < 90) begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(8, 30);
         end
      end
   end

   // Compare each output transfer against the oldest prediction
   always @(posedge clock) begin : output_checker
      resampled_type oldest;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            $error("unexpected output: value %0d last %0b", rsp_value, rsp_last);
            error_count++;
         end else begin
            oldest = pending_outputs.pop_front();
            outputs_checked++;
            if (rsp_value !== oldest.value) begin
               $error("value mismatch: expected %0d, actual %0d", oldest.value, rsp_value);
               error_count++;
            end
            if (rsp_last !== oldest.last) begin
               $error("last mismatch: expected %0b, actual %0b", oldest.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      rsp_stall  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = par_pkg::CSR_INPUT_LENGTH;
      csr_wdata  = '0;
      stall_hold = 0;
      error_count     = 0;
      samples_sent    = 0;
      random_sent     = 0;
      outputs_checked = 0;
      register_writes = 0;
      gaps_enabled    = 1'b1;
      stalls_enabled  = 1'b1;
      input_length_reg  = par_pkg::INPUT_LENGTH_RST;
      output_length_reg = par_pkg::OUTPUT_LENGTH_RST;
      clear_series_state();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_lengths();
      test_segment_means();
      test_unmapped_index();
      test_upsample_repeat();
      test_upsample_cap();
      test_zero_lengths();
      test_saturated_lengths();
      test_random_series();

      // Drain, then watch for stray outputs
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d samples under %0d register writes, checked %0d resampled outputs",
               samples_sent, register_writes, outputs_checked);
      $display("Covered segment means, repeats, the 64x cap, zero and saturated lengths");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Run time limit
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
